[hdl/tts_pkg.sv]
// shared types, constants and register codes for the two-track step sequencer
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

  localparam int TimeW    = 48;
  localparam int DebW     = 20;
  localparam int LongW    = 24;
  localparam int IvlW     = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int StepOutW = 4;

  localparam int StepsDefault = 16;

  localparam logic [DebW-1:0]  DebounceReset  = DebW'(10000);
  localparam logic [LongW-1:0] LongpressReset = LongW'(500000);
  localparam logic [IvlW-1:0]  ClickIvlReset  = IvlW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce  = 2'd0,
    CfgLongpress = 2'd1,
    CfgClickIvl  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [DebW-1:0]  debounce_us;
    logic [LongW-1:0] longpress_us;
    logic [IvlW-1:0]  click_interval;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic             button_level;
    logic [TimeW-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic                click;
    logic                click_accent;
    logic                bass_note;
    logic                snare_note;
    logic                led_on;
    logic [StepOutW-1:0] step_index;
    logic                is_recording;
    logic                selected_track;
  } res_t;

endpackage
`default_nettype wire

[hdl/two_track_step_sequencer_core.sv]
// top level of the two-track step sequencer: request and result registers
// an accepted request passes through the request register and then the result register
// throughput: one request per cycle unless the result output stalls, set by the
// single-pass state update between the request register and the result register
// reset: patterns, step, track, recording and button tracking cleared (previous
// button level set high), configuration back to defaults; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module two_track_step_sequencer_core #(
  parameter int Steps = tts_pkg::StepsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [tts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [tts_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          mode_i,
  input  wire                          button_level_i,
  input  wire [tts_pkg::TimeW-1:0]     now_us_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         click_o,
  output logic                         click_accent_o,
  output logic                         bass_note_o,
  output logic                         snare_note_o,
  output logic                         led_on_o,
  output logic [tts_pkg::StepOutW-1:0] step_index_o,
  output logic                         is_recording_o,
  output logic                         selected_track_o
);

  tts_pkg::cfg_t  cfg;
  tts_pkg::item_t in_q;
  tts_pkg::res_t  res, out_q;
  logic           in_vld_q, out_vld_q;
  logic           advance;

  assign cfg_ready_o = 1'b1;

  tts_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q.mode         <= mode_i;
      in_q.button_level <= button_level_i;
      in_q.now_us       <= now_us_i;
    end
  end

  tts_seq_state #(.Steps(Steps)) u_seq_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .cfg_i  (cfg),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign click_o          = out_q.click;
  assign click_accent_o   = out_q.click_accent;
  assign bass_note_o      = out_q.bass_note;
  assign snare_note_o     = out_q.snare_note;
  assign led_on_o         = out_q.led_on;
  assign step_index_o     = out_q.step_index;
  assign is_recording_o   = out_q.is_recording;
  assign selected_track_o = out_q.selected_track;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("request register empty but not ready");

  a_button_no_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_q.mode |=> out_vld_q && !out_q.click && !out_q.click_accent)
    else $error("button request produced a click");

  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !out_ready_i |=> in_vld_q && $stable(in_q))
    else $error("stalled request lost");

  a_accent_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.click_accent |-> out_q.click)
    else $error("accent without click");

endmodule
`default_nettype wire

[hdl/tts_cfg_regs.sv]
// configuration register file
`timescale 1ns / 1ps
`default_nettype none
module tts_cfg_regs (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_valid_i,
  input  wire [tts_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire [tts_pkg::CfgDataW-1:0]   cfg_data_i,
  output tts_pkg::cfg_t                 cfg_o
);

  tts_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tts_pkg::CfgDebounce:  cfg_d.debounce_us    = cfg_data_i[tts_pkg::DebW-1:0];
        tts_pkg::CfgLongpress: cfg_d.longpress_us   = cfg_data_i[tts_pkg::LongW-1:0];
        tts_pkg::CfgClickIvl:  cfg_d.click_interval = cfg_data_i[tts_pkg::IvlW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_us    <= tts_pkg::DebounceReset;
      cfg_q.longpress_us   <= tts_pkg::LongpressReset;
      cfg_q.click_interval <= tts_pkg::ClickIvlReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hdl/tts_click_div.sv]
// remainder of the step position by the click interval, one bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tts_click_div #(
  parameter int StepW = 4
) (
  input  wire [StepW-1:0]          step_i,
  input  wire [tts_pkg::IvlW-1:0]  ivl_i,
  output logic                     on_beat_o
);

  logic [tts_pkg::IvlW-1:0] ivl;
  logic [tts_pkg::IvlW-1:0] rem;
  logic [tts_pkg::IvlW:0]   part;

  // restoring remainder, rem always stays below the divisor
  always_comb begin
    ivl  = (ivl_i == '0) ? tts_pkg::IvlW'(1) : ivl_i;
    rem  = '0;
    part = '0;
    for (int i = StepW - 1; i >= 0; i--) begin
      part = {rem, step_i[i]};
      if (part >= {1'b0, ivl}) begin
        part = part - {1'b0, ivl};
      end
      rem = part[tts_pkg::IvlW-1:0];
    end
    on_beat_o = (rem == '0);
  end

endmodule
`default_nettype wire

[hdl/tts_seq_state.sv]
// sequencer state registers and the per-request update logic
`timescale 1ns / 1ps
`default_nettype none
module tts_seq_state #(
  parameter int Steps = tts_pkg::StepsDefault,
  parameter int StepW = $clog2(Steps)
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            fire_i,
  input  tts_pkg::cfg_t  cfg_i,
  input  tts_pkg::item_t item_i,
  output tts_pkg::res_t  res_o
);

  localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);
  localparam int PadDeb  = tts_pkg::TimeW - tts_pkg::DebW;
  localparam int PadLong = tts_pkg::TimeW - tts_pkg::LongW;

  logic [Steps-1:0]          bass_q, bass_d;
  logic [Steps-1:0]          snare_q, snare_d;
  logic [StepW-1:0]          step_q, step_d;
  logic                      sel_q, sel_d;
  logic                      rec_q, rec_d;
  logic                      toggle_q, toggle_d;
  logic                      press_q, press_d;
  logic                      long_q, long_d;
  logic                      prev_q, prev_d;
  logic [tts_pkg::TimeW-1:0] last_q, last_d;
  logic [tts_pkg::TimeW-1:0] ptime_q, ptime_d;
  logic                      led_q, led_d;

  logic                      btn, tick;
  logic [tts_pkg::TimeW-1:0] since_last, since_press;
  logic                      accept, long_hit, release_hit, record;
  logic                      press_n, long_n;
  logic [Steps-1:0]          step_bit;
  logic                      bset, sset, on_beat, last_step;
  logic [StepW+tts_pkg::StepOutW-1:0] step_ext;

  tts_click_div #(.StepW(StepW)) u_click_div (
    .step_i    (step_q),
    .ivl_i     (cfg_i.click_interval),
    .on_beat_o (on_beat)
  );

  always_comb begin
    btn  = !item_i.mode;
    tick = item_i.mode;

    since_last  = item_i.now_us - last_q;
    since_press = item_i.now_us - ptime_q;

    accept = btn && item_i.button_level && !prev_q &&
             (since_last >= {{PadDeb{1'b0}}, cfg_i.debounce_us});
    press_n = accept ? 1'b1 : press_q;
    long_n  = accept ? 1'b0 : long_q;

    // a freshly accepted press has zero hold time
    long_hit = btn && item_i.button_level && press_n && !long_n &&
               (accept ? (cfg_i.longpress_us == '0)
                       : (since_press >= {{PadLong{1'b0}}, cfg_i.longpress_us}));
    release_hit = btn && !item_i.button_level && prev_q && press_n;
    record      = release_hit && !long_n;

    step_bit  = Steps'(1) << step_q;
    bset      = bass_q[step_q];
    sset      = snare_q[step_q];
    last_step = (step_q == LastStep);

    bass_d   = bass_q;
    snare_d  = snare_q;
    step_d   = step_q;
    sel_d    = sel_q;
    rec_d    = rec_q;
    toggle_d = toggle_q;
    press_d  = press_q;
    long_d   = long_q;
    prev_d   = prev_q;
    last_d   = last_q;
    ptime_d  = ptime_q;
    led_d    = led_q;

    res_o = '0;

    if (btn) begin
      if (accept) begin
        last_d  = item_i.now_us;
        ptime_d = item_i.now_us;
        res_o.bass_note  = !sel_q;
        res_o.snare_note = sel_q;
      end
      press_d = release_hit ? 1'b0 : press_n;
      long_d  = long_hit ? 1'b1 : long_n;
      if (long_hit) begin
        toggle_d = 1'b1;
      end
      prev_d = item_i.button_level;
      if (record) begin
        rec_d = 1'b1;
        // first recorded step clears the selected track
        if (!sel_q) begin
          bass_d = (rec_q ? bass_q : '0) | step_bit;
        end else begin
          snare_d = (rec_q ? snare_q : '0) | step_bit;
        end
      end
    end else if (tick) begin
      res_o.click        = on_beat;
      res_o.click_accent = on_beat && (step_q == '0);
      if ((!rec_q || sel_q) && bset) begin
        res_o.bass_note = 1'b1;
        led_d = 1'b1;
      end
      if ((!rec_q || !sel_q) && sset) begin
        res_o.snare_note = 1'b1;
      end
      if (!bset) begin
        led_d = 1'b0;
      end
      if (rec_q && last_step) begin
        rec_d = 1'b0;
        led_d = 1'b0;
      end
      if (toggle_q) begin
        sel_d    = !sel_q;
        toggle_d = 1'b0;
      end
      step_d = last_step ? '0 : step_q + StepW'(1);
    end

    step_ext = {{tts_pkg::StepOutW{1'b0}}, step_d};
    res_o.led_on         = led_d;
    res_o.step_index     = step_ext[tts_pkg::StepOutW-1:0];
    res_o.is_recording   = rec_d;
    res_o.selected_track = sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bass_q   <= '0;
      snare_q  <= '0;
      step_q   <= '0;
      sel_q    <= 1'b0;
      rec_q    <= 1'b0;
      toggle_q <= 1'b0;
      press_q  <= 1'b0;
      long_q   <= 1'b0;
      prev_q   <= 1'b1;
      last_q   <= '0;
      ptime_q  <= '0;
      led_q    <= 1'b0;
    end else if (fire_i) begin
      bass_q   <= bass_d;
      snare_q  <= snare_d;
      step_q   <= step_d;
      sel_q    <= sel_d;
      rec_q    <= rec_d;
      toggle_q <= toggle_d;
      press_q  <= press_d;
      long_q   <= long_d;
      prev_q   <= prev_d;
      last_q   <= last_d;
      ptime_q  <= ptime_d;
      led_q    <= led_d;
    end
  end

endmodule
`default_nettype wire
